@@ hw/rtl/rlefill_pkg.sv @@
package rlefill_pkg;

  localparam int unsigned DimW   = 10;
  localparam int unsigned LenW   = 16;
  localparam int unsigned ColorW = 16;

  localparam logic [DimW-1:0] FrameWidthReset  = 10'd240;
  localparam logic [DimW-1:0] FrameHeightReset = 10'd320;

  // Configuration register indexes.
  localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

  // Result slots, emitted in this order.
  localparam int unsigned NumSlots = 4;
  localparam logic [1:0] SLOT_REST   = 2'd0;
  localparam logic [1:0] SLOT_BLOCK  = 2'd1;
  localparam logic [1:0] SLOT_LEAD   = 2'd2;
  localparam logic [1:0] SLOT_STATUS = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_REST,
    ST_REST_UPD,
    ST_CHK_BLOCK,
    ST_DIV_WAIT,
    ST_BLOCK,
    ST_LEAD,
    ST_STAT,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [DimW-1:0] row;
    logic [DimW-1:0] col;
    logic [DimW-1:0] width;
    logic [DimW-1:0] rows;
  } fill_slot_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

@@ hw/rtl/rlefill_div.sv @@
module rlefill_div
  import rlefill_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [LenW-1:0] dividend,
  input  logic [DimW-1:0] divisor,
  output logic            done,
  output logic [LenW-1:0] quotient,
  output logic [DimW-1:0] remainder
);

  logic                         busy;
  logic [$clog2(LenW)-1:0]      cnt;
  logic [LenW-1:0]              quo;
  logic [DimW-1:0]              rem;
  logic [DimW:0]                rem_sh;
  logic [DimW:0]                diff;
  logic                         fits;

  // One quotient bit per cycle, restoring.
  assign rem_sh = {rem, quo[LenW-1]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= $clog2(LenW)'(LenW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[DimW-1:0];
        quo <= {quo[LenW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DimW-1:0];
        quo <= {quo[LenW-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ hw/rtl/rle_rgb565_area_fill_core.sv @@
// Run-length decoder for a full-screen RGB565 image that turns each run record
// into rectangle fills for a display engine.
// Input channel (in_valid/in_ready): one beat is one run record with its length,
// color and an end-of-image mark. Output channel (out_valid/out_ready): one beat
// is one fill rectangle or one end-of-image status; last_of_item marks the final
// beat caused by a record. A record gives zero to four beats.
// Configuration: cfg_we writes frame_width (index 0) or frame_height (index 1)
// in the same cycle; write only while no record is in flight.
// Timing: the block works on one record at a time and drops in_ready from the
// accept until the last result slot of that record has been walked.
// A record of zero length, zero width or full frame is skipped without fills.
// Finishing a partly filled row adds the state ST_REST_UPD, and a whole-row
// block adds ST_DIV_WAIT and ST_BLOCK, waiting in ST_DIV_WAIT on the
// 16-step shift-subtract divider that finds the row count.
// The output register lets a new record be accepted while its last beat waits.
// When the receiver stalls, the output beat holds and the sequencer waits
// before handing over the next result.
// Reset clears the position to row 0, column 0, restores the frame size to
// 240 by 320, and empties the output register.
module rle_rgb565_area_fill_core
  import rlefill_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [DimW-1:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [LenW-1:0]   run_length,
  input  logic [ColorW-1:0] pixel_color,
  input  logic              end_of_image,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              is_status,
  output logic [DimW-1:0]   start_row,
  output logic [DimW-1:0]   start_col,
  output logic [DimW-1:0]   fill_width,
  output logic [DimW-1:0]   fill_rows,
  output logic [ColorW-1:0] fill_color,
  output logic              frame_ok,
  output logic              last_of_item
);

  seq_state_t state, state_next;

  logic [DimW-1:0]   frame_width;
  logic [DimW-1:0]   frame_height;
  logic [DimW-1:0]   cur_col;
  logic [DimW-1:0]   cur_row;
  logic [LenW-1:0]   len;
  logic [ColorW-1:0] color;
  logic              last;
  logic [DimW-1:0]   take;
  fill_slot_t        slot [NumSlots];
  logic [NumSlots-1:0] slot_vld;
  logic              stat_ok;
  logic [1:0]        emit_idx;

  div_ctl_t          div_ctl;
  logic [LenW-1:0]   div_quo;
  logic [DimW-1:0]   div_rem;

  // Shared conditions of the current position.
  logic              row_in;
  logic              run_go;
  logic              len_ge_w;
  logic [DimW-1:0]   take_full;
  logic [DimW-1:0]   col_sum;
  logic [DimW-1:0]   avail;
  logic              clip;
  logic              out_free;
  logic              cur_vld;
  logic              later_vld;
  logic [NumSlots-1:0] above_mask;
  logic              accept;
  logic              load;

  assign row_in    = cur_row < frame_height;
  assign run_go    = (len != '0) && (frame_width != '0) && row_in;
  assign len_ge_w  = len >= {{(LenW-DimW){1'b0}}, frame_width};
  assign take_full = frame_width - cur_col;
  assign col_sum   = cur_col + take;
  assign avail     = frame_height - cur_row;
  assign clip      = div_quo > {{(LenW-DimW){1'b0}}, avail};
  assign out_free  = !out_valid || out_ready;
  assign cur_vld   = slot_vld[emit_idx];
  assign above_mask = ~((NumSlots'(2) << emit_idx) - NumSlots'(1));
  assign later_vld = |(slot_vld & above_mask);
  assign accept    = in_valid && in_ready;

  rlefill_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_ctl.start),
    .dividend  (len),
    .divisor   (frame_width),
    .done      (div_ctl.done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and control strobes.
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    div_ctl.start = 1'b0;
    load          = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = run_go ? ST_REST : ST_STAT;
      end
      ST_REST: begin
        state_next = (row_in && cur_col != '0) ? ST_REST_UPD : ST_CHK_BLOCK;
      end
      ST_REST_UPD: begin
        state_next = ST_CHK_BLOCK;
      end
      ST_CHK_BLOCK: begin
        if (row_in && len_ge_w) begin
          div_ctl.start = 1'b1;
          state_next    = ST_DIV_WAIT;
        end else begin
          state_next = ST_LEAD;
        end
      end
      ST_DIV_WAIT: begin
        if (div_ctl.done) begin
          state_next = ST_BLOCK;
        end
      end
      ST_BLOCK: begin
        state_next = ST_LEAD;
      end
      ST_LEAD: begin
        state_next = ST_STAT;
      end
      ST_STAT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!cur_vld || out_free) begin
          load = cur_vld;
          if (emit_idx == SLOT_STATUS) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration, position and slot bookkeeping registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FrameWidthReset;
      frame_height <= FrameHeightReset;
      cur_col      <= '0;
      cur_row      <= '0;
      slot_vld     <= '0;
      emit_idx     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width  <= cfg_wdata;
          CFG_FRAME_HEIGHT: frame_height <= cfg_wdata;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            slot_vld <= '0;
            emit_idx <= SLOT_REST;
          end
        end
        ST_PREP: begin
          // A column at or past the width closes the row without a fill.
          if (run_go && cur_col >= frame_width) begin
            cur_col <= '0;
            cur_row <= cur_row + 1'b1;
          end
        end
        ST_REST_UPD: begin
          slot_vld[SLOT_REST] <= 1'b1;
          if (col_sum == frame_width) begin
            cur_col <= '0;
            cur_row <= cur_row + 1'b1;
          end else begin
            cur_col <= col_sum;
          end
        end
        ST_BLOCK: begin
          slot_vld[SLOT_BLOCK] <= 1'b1;
          if (clip) begin
            cur_row <= frame_height;
          end else begin
            cur_row <= cur_row + div_quo[DimW-1:0];
          end
        end
        ST_LEAD: begin
          if (row_in && len != '0) begin
            slot_vld[SLOT_LEAD] <= 1'b1;
            cur_col <= len[DimW-1:0];
          end
        end
        ST_STAT: begin
          if (last) begin
            slot_vld[SLOT_STATUS] <= 1'b1;
            cur_col <= '0;
            cur_row <= '0;
          end
        end
        ST_EMIT: begin
          if (!cur_vld || out_free) begin
            emit_idx <= emit_idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Run payload and result slots.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          len   <= run_length;
          color <= pixel_color;
          last  <= end_of_image;
        end
      end
      ST_REST: begin
        take <= (len < {{(LenW-DimW){1'b0}}, take_full}) ? len[DimW-1:0] : take_full;
      end
      ST_REST_UPD: begin
        slot[SLOT_REST] <= '{row: cur_row, col: cur_col, width: take, rows: DimW'(1)};
        len <= len - {{(LenW-DimW){1'b0}}, take};
      end
      ST_BLOCK: begin
        slot[SLOT_BLOCK] <= '{row: cur_row, col: '0, width: frame_width,
                              rows: clip ? avail : div_quo[DimW-1:0]};
        len <= clip ? '0 : {{(LenW-DimW){1'b0}}, div_rem};
      end
      ST_LEAD: begin
        slot[SLOT_LEAD] <= '{row: cur_row, col: '0, width: len[DimW-1:0],
                             rows: DimW'(1)};
      end
      ST_STAT: begin
        slot[SLOT_STATUS] <= '{row: '0, col: '0, width: '0, rows: '0};
        stat_ok <= (cur_row == frame_height);
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_status    <= (emit_idx == SLOT_STATUS);
      start_row    <= slot[emit_idx].row;
      start_col    <= slot[emit_idx].col;
      fill_width   <= slot[emit_idx].width;
      fill_rows    <= slot[emit_idx].rows;
      fill_color   <= (emit_idx == SLOT_STATUS) ? '0 : color;
      frame_ok     <= (emit_idx == SLOT_STATUS) && stat_ok;
      last_of_item <= !later_vld;
    end
  end

endmodule

@@ hw/rtl/rlefill_chk.sv @@
module rlefill_chk
  import rlefill_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              is_status,
  input logic [DimW-1:0]   start_row,
  input logic [DimW-1:0]   start_col,
  input logic [DimW-1:0]   fill_width,
  input logic [DimW-1:0]   fill_rows,
  input logic [ColorW-1:0] fill_color,
  input logic              frame_ok,
  input logic              last_of_item
);

  // A stalled result beat stays valid and keeps its width, start row, status flag and last mark.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fill_width) && $stable(start_row)
      && $stable(is_status) && $stable(last_of_item))
    else $error("output beat changed while stalled");

  // Status always closes the record's results.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status |-> last_of_item)
    else $error("status beat not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status |-> fill_width == '0 && fill_rows == '0
      && start_row == '0 && start_col == '0 && fill_color == '0)
    else $error("status beat carries fill fields");

  // Every fill covers at least one pixel and never reports frame_ok.
  a_fill_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_status |-> fill_width != '0 && fill_rows != '0 && !frame_ok)
    else $error("empty fill or stray frame_ok");

  // One record is worked on at a time.
  a_one_record: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("record accepted while another is in flight");

endmodule

bind rle_rgb565_area_fill_core rlefill_chk u_rlefill_chk (.*);
